>>> design/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and codes for the stack machine execute unit.
// ----------------------------------------------------------------------------
package smx_pkg;

    // Opcode values as they arrive on the request port
    localparam logic [7:0] OP_HALT = 8'd0;
    localparam logic [7:0] OP_PUSH = 8'd1;
    localparam logic [7:0] OP_ADD  = 8'd2;
    localparam logic [7:0] OP_MUL  = 8'd3;
    localparam logic [7:0] OP_POP  = 8'd4;
    localparam logic [7:0] OP_LOAD = 8'd5;

    // Depth of the queues between front, back and result port
    localparam int QUEUE_DEPTH = 2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_HALTED    = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_ILLEGAL   = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_BAD_REG   = 3'd5
    } status_t;

    // Decoded instruction class
    typedef enum logic [2:0] {
        CLS_HALT,
        CLS_PUSH,
        CLS_ADD,
        CLS_MUL,
        CLS_POP,
        CLS_LOAD,
        CLS_ILLEGAL
    } op_class_t;

    // Decoded instruction handed from front to back
    typedef struct packed {
        op_class_t          cls;
        logic               reg_ok;
        logic [2:0]         reg_index;
        logic signed [31:0] push_value;
    } instr_t;

    // One result as presented on the result port
    typedef struct packed {
        status_t            status;
        logic               top_valid;
        logic signed [31:0] top_value;
        logic [4:0]         depth;
        logic signed [31:0] reg_value;
        logic               halted;
    } result_t;

endpackage

>>> design/smx_fifo.sv
// ----------------------------------------------------------------------------
// smx_fifo
// Small register-based queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module smx_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Occupancy update
    always_comb
    begin
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> design/smx_front.sv
// ----------------------------------------------------------------------------
// smx_front
// Accepts requests, decodes the opcode and checks the register index,
// then queues the decoded instruction for the execute stage.
// ----------------------------------------------------------------------------
module smx_front
    import smx_pkg::*;
#(
    parameter int REG_COUNT = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         opcode,
    input  logic signed [31:0] push_value,
    input  logic [2:0]         reg_index,
    output instr_t             instr,
    output logic               instr_valid,
    input  logic               instr_take
);

    instr_t decoded;
    logic   queue_empty;

    // Opcode classification
    always_comb
    begin
        decoded.push_value = push_value;
        decoded.reg_index  = reg_index;
        decoded.reg_ok     = ({1'b0, reg_index} < 4'(REG_COUNT));
        case (opcode)
            OP_HALT: decoded.cls = CLS_HALT;
            OP_PUSH: decoded.cls = CLS_PUSH;
            OP_ADD:  decoded.cls = CLS_ADD;
            OP_MUL:  decoded.cls = CLS_MUL;
            OP_POP:  decoded.cls = CLS_POP;
            OP_LOAD: decoded.cls = CLS_LOAD;
            default: decoded.cls = CLS_ILLEGAL;
        endcase
    end

    // Instruction queue toward the execute stage
    smx_fifo #(
        .WIDTH ($bits(instr_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_instr_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .wr_data (decoded),
        .pop     (instr_take),
        .empty   (queue_empty),
        .rd_data (instr)
    );

    assign instr_valid = !queue_empty;

endmodule

>>> design/smx_back.sv
// ----------------------------------------------------------------------------
// smx_back
// Execute stage: holds the stack (top two entries in registers, the rest in
// a memory with a prefetched third entry), the register file and the halt
// flag, and queues one result per instruction.
// ----------------------------------------------------------------------------
module smx_back
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int REG_COUNT   = 5,
    parameter int DATA_WIDTH  = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    input  instr_t  instr,
    input  logic    instr_valid,
    output logic    instr_take,
    output result_t res,
    output logic    res_empty,
    input  logic    res_pop
);

    localparam int  CW        = $clog2(STACK_DEPTH + 1);
    localparam int  MEM_DEPTH = (STACK_DEPTH > 2) ? STACK_DEPTH - 2 : 1;
    localparam int  MAW       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int  RW        = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam bit  WIDE_MUL  = (DATA_WIDTH > 32);

    // Stack and machine state
    logic [DATA_WIDTH-1:0] stack_mem [MEM_DEPTH];
    logic [DATA_WIDTH-1:0] tos_reg, tos_next;
    logic [DATA_WIDTH-1:0] nos_reg, nos_next;
    logic [DATA_WIDTH-1:0] third_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [DATA_WIDTH-1:0] regs_reg [REG_COUNT];
    logic                  halt_reg, halt_next;
    logic                  mul_phase_reg;

    logic                  res_full;
    logic                  go;
    logic                  fire;
    logic                  mul_first;
    logic                  do_push;
    logic                  do_pop;
    logic                  reg_we;
    status_t               status_next;
    logic [DATA_WIDTH-1:0] mul_result;
    logic [DATA_WIDTH-1:0] push_ext;
    logic [DATA_WIDTH-1:0] reg_read;
    result_t               res_next;

    assign push_ext = DATA_WIDTH'(instr.push_value);

    // Multiplier: combinational up to 32 bits, registered low and cross partial products above
    if (WIDE_MUL)
    begin : g_wide_mul
        localparam int HW = DATA_WIDTH - 32;
        logic [63:0]   pp_low_reg;
        logic [HW-1:0] pp_cross_reg;

        always_ff @(posedge clk)
        begin
            if (mul_first)
            begin
                pp_low_reg   <= tos_reg[31:0] * nos_reg[31:0];
                pp_cross_reg <= HW'(tos_reg[DATA_WIDTH-1:32] * nos_reg[HW-1:0]
                              + tos_reg[HW-1:0] * nos_reg[DATA_WIDTH-1:32]);
            end
        end

        assign mul_result = pp_low_reg[DATA_WIDTH-1:0] + {pp_cross_reg, 32'b0};
    end
    else
    begin : g_narrow_mul
        assign mul_result = tos_reg * nos_reg;
    end

    // Issue control
    assign go         = instr_valid && !res_full;
    assign mul_first  = WIDE_MUL && go && !halt_reg && (instr.cls == CLS_MUL)
                        && (count_reg >= 2'd2) && !mul_phase_reg;
    assign fire       = go && !mul_first;
    assign instr_take = fire;

    // Instruction execution
    always_comb
    begin
        status_next = ST_OK;
        halt_next   = halt_reg;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        reg_we      = 1'b0;
        tos_next    = tos_reg;
        nos_next    = nos_reg;
        count_next  = count_reg;

        if (halt_reg)
        begin
            status_next = ST_HALTED;
        end
        else
        begin
            case (instr.cls)
                CLS_HALT:
                begin
                    status_next = ST_HALTED;
                    halt_next   = 1'b1;
                end
                CLS_PUSH:
                begin
                    if (count_reg == CW'(STACK_DEPTH))
                    begin
                        status_next = ST_OVERFLOW;
                        halt_next   = 1'b1;
                    end
                    else
                    begin
                        do_push = 1'b1;
                    end
                end
                CLS_ADD, CLS_MUL:
                begin
                    if (count_reg < 2'd2)
                    begin
                        status_next = ST_UNDERFLOW;
                        halt_next   = 1'b1;
                    end
                    else
                    begin
                        do_pop = 1'b1;
                    end
                end
                CLS_POP:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_UNDERFLOW;
                        halt_next   = 1'b1;
                    end
                    else
                    begin
                        do_pop = 1'b1;
                    end
                end
                CLS_LOAD:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_UNDERFLOW;
                        halt_next   = 1'b1;
                    end
                    else if (!instr.reg_ok)
                    begin
                        status_next = ST_BAD_REG;
                        halt_next   = 1'b1;
                    end
                    else
                    begin
                        do_pop = 1'b1;
                        reg_we = 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_ILLEGAL;
                    halt_next   = 1'b1;
                end
            endcase
        end

        // Top-of-stack movement
        if (do_push)
        begin
            tos_next   = push_ext;
            nos_next   = tos_reg;
            count_next = count_reg + 1'b1;
        end
        else if (do_pop)
        begin
            case (instr.cls)
                CLS_ADD: tos_next = tos_reg + nos_reg;
                CLS_MUL: tos_next = mul_result;
                default: tos_next = nos_reg;
            endcase
            nos_next   = third_reg;
            count_next = count_reg - 1'b1;
        end
    end

    // Register value reported with the result, after this step
    assign reg_read = reg_we ? tos_reg : regs_reg[instr.reg_index[RW-1:0]];

    // Result assembly
    always_comb
    begin
        res_next.status    = status_next;
        res_next.top_valid = (count_next != '0);
        res_next.top_value = (count_next != '0) ? 32'(tos_next) : 32'sd0;
        res_next.depth     = 5'(count_next);
        res_next.reg_value = instr.reg_ok ? 32'(reg_read) : 32'sd0;
        res_next.halted    = halt_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            halt_reg      <= 1'b0;
            mul_phase_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            if (mul_first)
            begin
                mul_phase_reg <= 1'b1;
            end
            else if (fire)
            begin
                mul_phase_reg <= 1'b0;
            end
            if (fire)
            begin
                count_reg <= count_next;
                halt_reg  <= halt_next;
                if (reg_we)
                begin
                    regs_reg[instr.reg_index[RW-1:0]] <= tos_reg;
                end
            end
        end
    end

    // Top two entries
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            tos_reg <= tos_next;
            nos_reg <= nos_next;
        end
    end

    // Spill memory with prefetched third entry
    always_ff @(posedge clk)
    begin
        if (fire && do_push && (count_reg >= 2'd2))
        begin
            stack_mem[MAW'(count_reg - 2'd2)] <= nos_reg;
        end
        if (fire && do_push)
        begin
            third_reg <= nos_reg;
        end
        else if (fire && do_pop && (count_reg >= 3'd4))
        begin
            third_reg <= stack_mem[MAW'(count_reg - 3'd4)];
        end
    end

    // Result queue
    smx_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fire),
        .full    (res_full),
        .wr_data (res_next),
        .pop     (res_pop),
        .empty   (res_empty),
        .rd_data (res)
    );

`ifndef NO_ASSERTIONS
    // Stack depth never goes past its capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count above capacity");

    // Once halted, the machine stays halted and the stack is frozen
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg && $stable(count_reg))
        else $error("halted machine changed state");

    // Any non-ok status from a running machine leaves it halted
    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (status_next != ST_OK) |=> halt_reg)
        else $error("error status without halt");

    // A split multiply always finds its instruction still at the queue head
    a_mul_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mul_phase_reg |-> instr_valid && (instr.cls == CLS_MUL) && !halt_reg)
        else $error("multiply second half without its instruction");
`endif

endmodule

>>> design/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Flow: a request is queued in the front, executed from the queue head, and its
//   result is queued in the result queue, from which it is popped.
// Throughput: one instruction per cycle while the result queue has room; when
//   DATA_WIDTH exceeds 32, a multiply first registers its partial products.
// Reset clears stack depth, registers, halt flag and both queues at once;
//   stack memory is not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int REG_COUNT   = 5,
    parameter int DATA_WIDTH  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         opcode,
    input  logic signed [31:0] push_value,
    input  logic [2:0]         reg_index,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         status,
    output logic               top_valid,
    output logic signed [31:0] top_value,
    output logic [4:0]         depth,
    output logic signed [31:0] reg_value,
    output logic               halted
);

    instr_t  instr;
    logic    instr_valid;
    logic    instr_take;
    result_t res;

    // Front: accept and decode requests
    smx_front #(
        .REG_COUNT (REG_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .push_value  (push_value),
        .reg_index   (reg_index),
        .instr       (instr),
        .instr_valid (instr_valid),
        .instr_take  (instr_take)
    );

    // Back: execute and queue results
    smx_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .REG_COUNT   (REG_COUNT),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr       (instr),
        .instr_valid (instr_valid),
        .instr_take  (instr_take),
        .res         (res),
        .res_empty   (empty),
        .res_pop     (pop)
    );

    // Result fields
    assign status    = res.status;
    assign top_valid = res.top_valid;
    assign top_value = res.top_value;
    assign depth     = res.depth;
    assign reg_value = res.reg_value;
    assign halted    = res.halted;

endmodule
